// File: design/ldfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ldfp_pkg;

  // framing and payload characters
  localparam logic [7:0] CH_MARK  = 8'h44;  // 'D'
  localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
  localparam logic [7:0] CH_END   = 8'h6D;  // 'm'
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int MAX_PAYLOAD_DEF = 6;
  localparam int FRAC_DIGITS     = 5;
  localparam int DIST_W          = 38;
  localparam int MAG_W           = DIST_W - 1;
  localparam int TMP_W           = MAG_W + 5;
  localparam int OUT_FIELDS_W    = 3 * DIST_W;
  localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int FRAC_IDX_W      = 3;

  localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MARK,
    FR_PAYLOAD
  } fr_state_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SCAN,
    CV_DONE
  } cv_state_t;

  // converter status toward the output stage
  typedef struct packed {
    logic busy;
    logic done;
  } cv_status_t;

  // integer digit weight: digit times 100000
  function automatic logic [19:0] int_term(input logic [3:0] d);
    logic [19:0] r;
    begin
      r = 20'(d) * 20'd100000;
      return r;
    end
  endfunction

  // fraction digit weight by position after the point
  function automatic logic [16:0] frac_term(input logic [3:0] d,
                                            input logic [FRAC_IDX_W-1:0] k);
    logic [13:0] w;
    begin
      unique case (k)
        3'd0:    w = 14'd10000;
        3'd1:    w = 14'd1000;
        3'd2:    w = 14'd100;
        3'd3:    w = 14'd10;
        3'd4:    w = 14'd1;
        default: w = 14'd0;
      endcase
      return 17'(d) * 17'(w);
    end
  endfunction

endpackage

`default_nettype wire

// File: design/laser_distance_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// laser rangefinder frame parser
// in_ channel: one received byte per word from the rangefinder serial link.
// frames look like 'D' '=' <up to MAX_PAYLOAD chars> 'm'; the payload is read
// as a decimal number (leading blanks, optional sign, digits, one point) and
// turned into a signed value in units of 1e-5.
// out_ channel: one word per completed frame carrying the new reading and the
// two readings before it; bytes that do not end a frame give no word.
// timing: a byte is taken in the cycle it is offered while in_tready is high. on 'm'
// the converter walks the buffered characters one per cycle, stopping at the
// first one that cannot continue the number; its result then moves into the output
// register. in_tready is low while the converter runs or holds a result.
// stall: the output register holds its word until out_tready; bytes are still
// taken meanwhile, but a second frame end's result waits in the converter, with
// in_tready low, until the held word leaves.
// reset (rst_n low, synchronous): framing goes idle, the buffer empties and
// the two stored readings return to zero.

module laser_distance_frame_parser #(
  parameter int MAX_PAYLOAD = ldfp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [37:0] distance, [75:38] prev_distance, [113:76] older_distance, rest zero
  output logic [ldfp_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int DW    = ldfp_pkg::DIST_W;

  logic                  in_acc;
  logic                  start;
  logic [7:0]            chars [MAX_PAYLOAD];
  logic [CNT_W-1:0]      count;
  ldfp_pkg::cv_status_t  cv_status;
  logic [DW-1:0]         result;
  logic                  load;

  // reading history
  logic [DW-1:0]         latest_r, previous_r;
  logic                  out_tvalid_r;
  logic [ldfp_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  assign in_tready = !cv_status.busy;
  assign in_acc    = in_tvalid && in_tready;

  ldfp_framer #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld_i (in_acc),
    .byte_i     (in_tdata),
    .start_o    (start),
    .chars_o    (chars),
    .count_o    (count)
  );

  ldfp_converter #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .chars_i  (chars),
    .count_i  (count),
    .ack_i    (load),
    .status_o (cv_status),
    .result_o (result)
  );

  // a finished conversion moves into the output register once it is free
  assign load = cv_status.done && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      latest_r     <= '0;
      previous_r   <= '0;
    end else begin
      if (load) begin
        out_tvalid_r <= 1'b1;
        latest_r     <= result;
        previous_r   <= latest_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= ldfp_pkg::OUT_TDATA_W'({previous_r, latest_r, result});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// File: design/ldfp_framer.sv
`timescale 1ns / 1ps
`default_nettype none

module ldfp_framer #(
  parameter int MAX_PAYLOAD = ldfp_pkg::MAX_PAYLOAD_DEF,
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_vld_i,
  input  wire logic [7:0]       byte_i,
  output logic                  start_o,
  output logic [7:0]            chars_o [MAX_PAYLOAD],
  output logic [CNT_W-1:0]      count_o
);

  ldfp_pkg::fr_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [7:0]       chars_r [MAX_PAYLOAD];
  logic             full;

  assign full = (count_r == CNT_W'(MAX_PAYLOAD));

  // next state
  always_comb begin
    state_nxt = state_r;
    if (byte_vld_i) begin
      unique case (state_r)
        ldfp_pkg::FR_MARK:
          state_nxt = (byte_i == ldfp_pkg::CH_EQUAL) ? ldfp_pkg::FR_PAYLOAD
                                                     : ldfp_pkg::FR_IDLE;
        ldfp_pkg::FR_PAYLOAD:
          if (byte_i == ldfp_pkg::CH_END || full) begin
            state_nxt = ldfp_pkg::FR_IDLE;
          end
        default:
          state_nxt = (byte_i == ldfp_pkg::CH_MARK) ? ldfp_pkg::FR_MARK
                                                    : ldfp_pkg::FR_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    start_o = byte_vld_i && (state_r == ldfp_pkg::FR_PAYLOAD) &&
              (byte_i == ldfp_pkg::CH_END);
    chars_o = chars_r;
    count_o = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldfp_pkg::FR_IDLE;
      count_r <= '0;
      for (int k = 0; k < MAX_PAYLOAD; k++) begin
        chars_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (byte_vld_i && state_r == ldfp_pkg::FR_PAYLOAD) begin
        if (byte_i == ldfp_pkg::CH_END || full) begin
          // frame end or overlong payload: empty the buffer
          count_r <= '0;
          for (int k = 0; k < MAX_PAYLOAD; k++) begin
            chars_r[k] <= '0;
          end
        end else begin
          for (int k = 0; k < MAX_PAYLOAD; k++) begin
            if (count_r == CNT_W'(k)) begin
              chars_r[k] <= byte_i;
            end
          end
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/ldfp_converter.sv
`timescale 1ns / 1ps
`default_nettype none

module ldfp_converter #(
  parameter int MAX_PAYLOAD = ldfp_pkg::MAX_PAYLOAD_DEF,
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start_i,
  input  wire logic [7:0]                   chars_i [MAX_PAYLOAD],
  input  wire logic [CNT_W-1:0]             count_i,
  input  wire logic                         ack_i,
  output ldfp_pkg::cv_status_t              status_o,
  output logic [ldfp_pkg::DIST_W-1:0]       result_o
);

  ldfp_pkg::cv_state_t state_r, state_nxt;

  logic [7:0]                       chars_r [MAX_PAYLOAD];
  logic [CNT_W-1:0]                 rem_r;
  logic [ldfp_pkg::MAG_W-1:0]       val_r, val_nxt;
  logic                             neg_r, neg_nxt;
  logic                             point_r, point_nxt;
  logic                             any_r, any_nxt;
  logic                             lead_r, lead_nxt;
  logic [ldfp_pkg::FRAC_IDX_W-1:0]  frac_r, frac_nxt;
  logic                             stop;

  logic [7:0]                       c;
  logic                             is_digit, is_blank, is_sign, is_point;
  logic [ldfp_pkg::TMP_W-1:0]       tmp;
  logic [ldfp_pkg::MAG_W-1:0]       mag;

  assign c        = chars_r[0];
  assign is_digit = (c >= ldfp_pkg::CH_ZERO) && (c <= ldfp_pkg::CH_NINE);
  assign is_blank = (c == ldfp_pkg::CH_SPACE) ||
                    ((c >= ldfp_pkg::CH_TAB) && (c <= ldfp_pkg::CH_CR));
  assign is_sign  = (c == ldfp_pkg::CH_PLUS) || (c == ldfp_pkg::CH_MINUS);
  assign is_point = (c == ldfp_pkg::CH_POINT);

  // one character per cycle
  always_comb begin
    val_nxt   = val_r;
    neg_nxt   = neg_r;
    point_nxt = point_r;
    any_nxt   = any_r;
    lead_nxt  = lead_r;
    frac_nxt  = frac_r;
    stop      = 1'b0;
    tmp       = ldfp_pkg::TMP_W'(val_r);
    if (lead_r && is_blank) begin
      lead_nxt = 1'b1;
    end else if (lead_r && is_sign) begin
      lead_nxt = 1'b0;
      neg_nxt  = (c == ldfp_pkg::CH_MINUS);
    end else begin
      lead_nxt = 1'b0;
      if (is_digit) begin
        any_nxt = 1'b1;
        if (!point_r) begin
          tmp = {2'b00, val_r, 3'b000} + {4'b0000, val_r, 1'b0} +
                ldfp_pkg::TMP_W'(ldfp_pkg::int_term(c[3:0]));
        end else if (frac_r < ldfp_pkg::FRAC_IDX_W'(ldfp_pkg::FRAC_DIGITS)) begin
          tmp = ldfp_pkg::TMP_W'(val_r) +
                ldfp_pkg::TMP_W'(ldfp_pkg::frac_term(c[3:0], frac_r));
          frac_nxt = frac_r + ldfp_pkg::FRAC_IDX_W'(1);
        end
        // saturate the magnitude
        val_nxt = (tmp > ldfp_pkg::TMP_W'(ldfp_pkg::MAG_CAP)) ? ldfp_pkg::MAG_CAP
                                                              : tmp[ldfp_pkg::MAG_W-1:0];
      end else if (is_point && !point_r) begin
        point_nxt = 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ldfp_pkg::CV_IDLE: if (start_i) state_nxt = ldfp_pkg::CV_SCAN;
      ldfp_pkg::CV_SCAN: if (rem_r == '0 || stop) state_nxt = ldfp_pkg::CV_DONE;
      ldfp_pkg::CV_DONE: if (ack_i) state_nxt = ldfp_pkg::CV_IDLE;
      default:           state_nxt = ldfp_pkg::CV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    status_o.busy = (state_r != ldfp_pkg::CV_IDLE);
    status_o.done = (state_r == ldfp_pkg::CV_DONE);
    mag           = any_r ? val_r : '0;
    result_o      = neg_r ? (ldfp_pkg::DIST_W'(0) - {1'b0, mag}) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldfp_pkg::CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ldfp_pkg::CV_IDLE && start_i) begin
      chars_r <= chars_i;
      rem_r   <= count_i;
      val_r   <= '0;
      neg_r   <= 1'b0;
      point_r <= 1'b0;
      any_r   <= 1'b0;
      lead_r  <= 1'b1;
      frac_r  <= '0;
    end else if (state_r == ldfp_pkg::CV_SCAN && rem_r != '0 && !stop) begin
      for (int k = 0; k < MAX_PAYLOAD - 1; k++) begin
        chars_r[k] <= chars_r[k+1];
      end
      chars_r[MAX_PAYLOAD-1] <= '0;
      rem_r   <= rem_r - CNT_W'(1);
      val_r   <= val_nxt;
      neg_r   <= neg_nxt;
      point_r <= point_nxt;
      any_r   <= any_nxt;
      lead_r  <= lead_nxt;
      frac_r  <= frac_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/ldfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ldfp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ldfp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // no word right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word after reset");

  // stalled word stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // a new result only comes out of a conversion, during which input is held off
  a_conv_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result word without a conversion");

  // padding bits above the three readings stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ldfp_pkg::OUT_TDATA_W-1:ldfp_pkg::OUT_FIELDS_W] == '0)
    else $error("nonzero padding in result word");

endmodule

bind laser_distance_frame_parser ldfp_checker u_ldfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
